### rtl/olt_pkg.sv
`default_nettype none
package olt_pkg;

   typedef enum logic [2:0] {
      REQ_NEW = 3'd0, REQ_ACK = 3'd1, REQ_FILL = 3'd2, REQ_CXL_REQ = 3'd3,
      REQ_CXLD = 3'd4, REQ_REJ = 3'd5, REQ_QUERY = 3'd6, REQ_UNUSED = 3'd7
   } req_code_type;

   typedef enum logic [2:0] {
      ST_PNEW = 3'd0, ST_ACC = 3'd1, ST_PCXL = 3'd2,
      ST_CXL = 3'd3, ST_FILL = 3'd4, ST_REJ = 3'd5
   } life_type;

   // back stage sequencer
   typedef enum logic [2:0] {B_IDLE, B_CLEAR, B_READ, B_EXEC, B_OUT} bstate_type;

   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_UNKNOWN  = 3'd1;
   localparam logic [2:0] STS_IGNORED  = 3'd2;
   localparam logic [2:0] STS_MISMATCH = 3'd3;
   localparam logic [2:0] STS_NO_CXL   = 3'd4;
   localparam logic [2:0] STS_CXL_PEND = 3'd5;

   localparam int ENTRY_W = 1 + 3 + 1 + 31 + 31 + 31 + 1;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [9:0]  order_id;
      logic [30:0] venue_ref;
      logic [30:0] order_qty_in;
      logic [30:0] fill_amount;
      logic        side_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  order_state;
      logic [30:0] order_qty_out;
      logic [30:0] filled_out;
      logic [30:0] venue_out;
      logic        venue_set;
      logic        side_out;
      logic [10:0] open_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  lifecycle;
      logic        side;
      logic [30:0] quantity;
      logic [30:0] filled;
      logic [30:0] venue;
      logic        venue_known;
   } entry_type;

   // front to back queue item
   typedef struct packed {
      req_type req;
      logic    in_range;
   } job_type;

   function automatic logic is_open(input logic [2:0] st);
      return st == ST_PNEW || st == ST_ACC || st == ST_PCXL;
   endfunction

endpackage
`default_nettype wire

### rtl/olt_ram.sv
`default_nettype none
module olt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/olt_front.sv
`default_nettype none
module olt_front #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire olt_pkg::req_type req_data,
   output      logic             q_valid,
   input  wire logic             q_take,
   output      olt_pkg::job_type q_data
);
   import olt_pkg::*;

   // two-entry queue; front accepts while not full
   job_type     slot_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        rp_ff, rp_in, wp_ff, wp_in;
   logic        push;
   job_type     job;

   // classify: id range check
   always_comb begin
      job.req      = req_data;
      job.in_range = 32'(req_data.order_id) < TABLE_DEPTH;
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_data    = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_take);
      rp_in  = rp_ff ^ q_take;
      wp_in  = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      if (push) slot_ff[wp_ff] <= job;
   end
endmodule
`default_nettype wire

### rtl/olt_back.sv
`default_nettype none
module olt_back #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output      logic             q_take,
   input  wire olt_pkg::job_type q_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      olt_pkg::rsp_type rsp_data
);
   import olt_pkg::*;
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   bstate_type state_ff, state_in;
   job_type    job_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [10:0] open_ff, open_in;
   rsp_type    rsp_ff, rsp_in;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type  cur, nxt, wr_entry;
   logic       wr_en, hit, new_open;
   logic [AW-1:0] addr, ram_addr;
   logic [2:0] status;
   logic [31:0] sum;

   assign addr = AW'(job_ff.req.order_id);
   assign cur  = entry_type'(rd_raw);

   // clearing pass owns the RAM port after reset
   assign ram_addr = (state_ff == B_CLEAR) ? clr_ff : addr;
   assign wr_entry = (state_ff == B_CLEAR) ? entry_type'('0) : nxt;

   olt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(ram_addr), .wr_data(wr_entry),
      .rd_addr(ram_addr), .rd_data(rd_raw)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(TABLE_DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE:  if (q_valid) state_in = B_READ;
         B_READ:  state_in = B_EXEC;
         B_EXEC:  state_in = B_OUT;
         B_OUT:   if (!rsp_stall) state_in = q_valid ? B_READ : B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_take    = (state_ff == B_IDLE && q_valid) ||
                  (state_ff == B_OUT && !rsp_stall && q_valid);
      rsp_valid = state_ff == B_OUT;
      wr_en     = 1'b0;
      case (state_ff)
         B_CLEAR: wr_en = 1'b1;
         B_EXEC:  wr_en = job_ff.in_range &&
                          (job_ff.req.req_type == REQ_NEW || hit);
         default: wr_en = 1'b0;
      endcase
   end

   // transition logic on the read entry
   always_comb begin
      hit      = job_ff.in_range && cur.valid;
      nxt      = cur;
      nxt.valid = 1'b1;
      status   = STS_OK;
      sum      = 32'(cur.filled) + 32'(job_ff.req.fill_amount);
      open_in  = open_ff;
      new_open = hit && is_open(cur.lifecycle);
      case (req_code_type'(job_ff.req.req_type))
         REQ_NEW: begin
            nxt.lifecycle = ST_PNEW;
            nxt.side = job_ff.req.side_in;
            nxt.quantity = job_ff.req.order_qty_in;
            nxt.filled = '0;
            nxt.venue = '0;
            nxt.venue_known = 1'b0;
         end
         REQ_ACK: begin
            if (cur.lifecycle == ST_REJ) status = STS_IGNORED;
            else begin
               nxt.venue = job_ff.req.venue_ref;
               nxt.venue_known = 1'b1;
               if (cur.lifecycle != ST_PCXL) nxt.lifecycle = ST_ACC;
            end
         end
         REQ_FILL: begin
            if (cur.lifecycle == ST_REJ || cur.lifecycle == ST_CXL) status = STS_IGNORED;
            else begin
               if (cur.venue_known && cur.venue != job_ff.req.venue_ref)
                  status = STS_MISMATCH;
               nxt.venue = job_ff.req.venue_ref;
               nxt.venue_known = 1'b1;
               if (sum >= 32'(cur.quantity)) begin
                  nxt.filled = cur.quantity;
                  nxt.lifecycle = ST_FILL;
               end else begin
                  nxt.filled = sum[30:0];
                  nxt.lifecycle = ST_ACC;
               end
            end
         end
         REQ_CXL_REQ: begin
            if (cur.lifecycle == ST_FILL || cur.lifecycle == ST_CXL ||
                cur.lifecycle == ST_REJ) status = STS_NO_CXL;
            else if (cur.lifecycle == ST_PCXL) status = STS_CXL_PEND;
            else nxt.lifecycle = ST_PCXL;
         end
         REQ_CXLD: begin
            if (cur.lifecycle == ST_REJ) status = STS_IGNORED;
            else begin
               if (cur.venue_known && cur.venue != job_ff.req.venue_ref)
                  status = STS_MISMATCH;
               nxt.venue = job_ff.req.venue_ref;
               nxt.venue_known = 1'b1;
               nxt.lifecycle = ST_CXL;
            end
         end
         REQ_REJ:   nxt.lifecycle = ST_REJ;
         REQ_QUERY: ;
         default:   status = STS_IGNORED;
      endcase
      if (job_ff.req.req_type == REQ_NEW) begin
         if (job_ff.in_range && !new_open) open_in = open_ff + 11'd1;
      end else if (hit) begin
         if (is_open(cur.lifecycle) && !is_open(nxt.lifecycle))
            open_in = open_ff - 11'd1;
         else if (!is_open(cur.lifecycle) && is_open(nxt.lifecycle))
            open_in = open_ff + 11'd1;
      end
      rsp_in = '0;
      rsp_in.open_count = open_in;
      if (job_ff.in_range && (job_ff.req.req_type == REQ_NEW || hit)) begin
         rsp_in.status        = (job_ff.req.req_type == REQ_NEW) ? STS_OK : status;
         rsp_in.order_state   = nxt.lifecycle;
         rsp_in.order_qty_out = nxt.quantity;
         rsp_in.filled_out    = nxt.filled;
         rsp_in.venue_out     = nxt.venue;
         rsp_in.venue_set     = nxt.venue_known;
         rsp_in.side_out      = nxt.side;
      end else begin
         rsp_in.status = STS_UNKNOWN;
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         open_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (state_ff == B_EXEC) open_ff <= open_in;
      end
      if (q_take) job_ff <= q_data;
      if (state_ff == B_EXEC) rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

### rtl/order_lifecycle_table.sv
`default_nettype none
// Order lifecycle table.
// Request channel (req_valid/req_stall/req_data) carries one order event:
// new, ack, fill, cancel request, cancelled, reject or query, by order id.
// Response channel (rsp_valid/rsp_stall/rsp_data) returns one item per
// request: status, the entry after the update and the open order count.
// A front stage checks the id range and buffers up to two requests; the
// back stage does a read-modify-write of the table RAM.
// The back stage works on one request at a time, through the RAM read,
// update and response register states of its sequencer; it takes the
// next when its response leaves.
// Reset clears the open count and starts a clearing pass that writes
// every table entry invalid. The front accepts up to two requests
// during the pass; the back stage takes the first when it ends.
// When rsp_stall is high the response holds, the back stage waits and the
// front queue fills, after which req_stall rises.
module order_lifecycle_table #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire olt_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      olt_pkg::rsp_type rsp_data
);
   import olt_pkg::*;

   logic    q_valid, q_take;
   job_type q_data;

   olt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   olt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

### rtl/olt_checker.sv
`default_nettype none
module olt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire olt_pkg::rsp_type rsp_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall
);
   import olt_pkg::*;

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");

   // no response right after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");

   // unknown id answers zero fields
   a_unk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STS_UNKNOWN |-> rsp_data.order_qty_out == '0
      && rsp_data.venue_set == 1'b0) else $error("unknown id fields");

   // fill never exceeds quantity
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.filled_out <= rsp_data.order_qty_out)
      else $error("fill over quantity");

   // no stall on request side right after reset
   a_rdy: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("stall after reset");
endmodule

bind order_lifecycle_table olt_checker u_olt_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_data, .rsp_valid, .rsp_stall
);
`default_nettype wire
